/* src/mlp_pkg.sv */
// Package for the online-learning MLP: constants, types and fixed-point helpers.
// Used by all modules of the block.
`timescale 1ns / 1ps
package mlp_pkg;

  localparam int FracBits    = 16;
  localparam int InputCount  = 8;
  localparam int HiddenCount = 8;
  localparam int WeightCount = 81;
  localparam int IdxW        = 7;
  localparam int AddrW       = 7;

  localparam logic [6:0] HbBase = 7'd64;
  localparam logic [6:0] OwBase = 7'd72;
  localparam logic [6:0] ObIdx  = 7'd80;

  localparam logic [16:0] LrReset    = 17'd655;
  localparam logic [30:0] ClampReset = 31'd65536;

  localparam logic [0:0] RegLr    = 1'b0;
  localparam logic [0:0] RegClamp = 1'b1;

  typedef enum logic [1:0] {
    REQ_FWD   = 2'd0,
    REQ_LEARN = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HID,
    ST_RELU,
    ST_OUT,
    ST_OBIAS,
    ST_DHID,
    ST_OW,
    ST_OB,
    ST_HW,
    ST_HB,
    ST_READ,
    ST_RESULT
  } state_t;

  // Operation requested from the shared multiply unit
  typedef struct packed {
    logic               go;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] q;
    logic               sat;
  } mul_rsp_t;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [33:0] v);
    return (v > 34'sd2147483647) || (v < -34'sd2147483648);
  endfunction

  function automatic logic signed [31:0] clampg(input logic signed [31:0] v,
                                                input logic [30:0] lim);
    logic signed [32:0] l;
    l = {2'b00, lim};
    if ($signed({v[31], v}) > l) begin
      return l[31:0];
    end else if ($signed({v[31], v}) < -l) begin
      return -l[31:0];
    end
    return v;
  endfunction

endpackage

/* src/mlp_mul.sv */
// Shared fixed-point multiplier: floor(a*b >> FRAC_BITS) saturated to 32 bits.
// Product and result are registered; pairs may overlap. Depends on mlp_pkg.
`timescale 1ns / 1ps
module mlp_mul import mlp_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic signed [63:0] prod;
  logic               prod_vld;
  logic signed [63:0] shifted;

  // Register the product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= req.go;
    end
    prod <= req.a * req.b;
  end

  // Arithmetic shift floors toward minus infinity
  assign shifted = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= prod_vld;
    end
    rsp.sat <= (shifted > 64'sd2147483647) || (shifted < -64'sd2147483648);
    if (shifted > 64'sd2147483647) begin
      rsp.q <= 32'sh7fffffff;
    end else if (shifted < -64'sd2147483648) begin
      rsp.q <= 32'sh80000000;
    end else begin
      rsp.q <= shifted[31:0];
    end
  end

endmodule

/* src/mlp_wmem.sv */
// Weight store: 81 entries, one write and one registered read port.
// Depends on mlp_pkg.
`timescale 1ns / 1ps
module mlp_wmem import mlp_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [AddrW-1:0]   waddr,
  input  logic signed [31:0] wdata,
  input  logic [AddrW-1:0]   raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [WeightCount];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mlp_8x8x1_online_learner.sv */
// 8-8-1 ReLU perceptron with online SGD in signed Q16.16. One shared
// multiplier and one weight memory do all the work under a sequencer,
// so the block works on one item at a time. After reset a clearing pass
// zeros all 81 weights before the first item is taken. Per item: a write
// is done as it is accepted; a read reads the memory and then loads its
// result; a forward forms 64 hidden products, each of which waits on the
// memory read and the registered multiplier, the ReLU of the 8 hidden sums,
// 8 output products, the output bias and the load of the result; a learn
// forms 8 hidden gradients, 8 output weights with the gradient product and
// the learning-rate product in series, the output bias, 64 hidden weights
// and 8 hidden biases.
// A result sits in an output register; the next item is taken meanwhile, but
// its own result waits in the sequencer and holds in_ready low until the
// register is free.
`timescale 1ns / 1ps
module mlp_8x8x1_online_learner import mlp_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] feature_0,
  input  logic signed [31:0] feature_1,
  input  logic signed [31:0] feature_2,
  input  logic signed [31:0] feature_3,
  input  logic signed [31:0] feature_4,
  input  logic signed [31:0] feature_5,
  input  logic signed [31:0] feature_6,
  input  logic signed [31:0] feature_7,
  input  logic signed [31:0] output_gradient,
  input  logic [6:0]         weight_index,
  input  logic signed [31:0] weight_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic signed [31:0] prediction,
  output logic signed [31:0] read_value,
  output logic               saturated
);

  // Configuration registers
  logic [16:0] learning_rate;
  logic [30:0] gradient_clamp;
  logic        cfg_wr;
  logic        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate  <= LrReset;
      gradient_clamp <= ClampReset;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      if (cfg_sel == RegLr) begin
        learning_rate <= pwdata[16:0];
      end else begin
        gradient_clamp <= pwdata[30:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (cfg_sel == RegLr) begin
        prdata = {15'd0, learning_rate};
      end else begin
        prdata = {1'b0, gradient_clamp};
      end
    end
  end

  // Datapath registers
  state_t             state, state_next;
  logic [1:0]         phase;
  logic [3:0]         i_cnt;
  logic [3:0]         j_cnt;
  logic [6:0]         clr_cnt;
  logic signed [31:0] feat   [InputCount];
  logic signed [31:0] hid    [HiddenCount];
  logic signed [31:0] dhid   [HiddenCount];
  logic signed [31:0] dout;
  logic signed [31:0] acc;
  logic signed [31:0] grad;
  logic               sat_flag;
  logic [6:0]         req_idx;
  req_t               req_type_q;
  logic               res_load;

  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic signed [31:0] wdata, rdata;
  mul_req_t           mreq;
  mul_rsp_t           mrsp;
  logic signed [33:0] sum;

  mlp_wmem u_wmem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  mlp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .req(mreq), .rsp(mrsp)
  );

  assign in_ready = (state == ST_IDLE);
  // Load the result register once it is free or being drained
  assign res_load = (state == ST_RESULT) && (!out_valid || out_ready);

  // Read address follows the loop counters
  always_comb begin
    raddr = req_idx;
    case (state)
      ST_HID: raddr = (phase == 2'd0 && i_cnt == 4'd0) ? HbBase + {3'd0, j_cnt}
                                                        : {1'b0, i_cnt[2:0], j_cnt[2:0]};
      ST_OUT, ST_DHID, ST_OW: raddr = OwBase + {3'd0, j_cnt};
      ST_OBIAS, ST_OB: raddr = ObIdx;
      ST_HW:   raddr = {1'b0, i_cnt[2:0], j_cnt[2:0]};
      ST_HB:   raddr = HbBase + {3'd0, j_cnt};
      default: raddr = req_idx;
    endcase
  end

  // Multiplier operand selection per phase
  always_comb begin
    mreq = '0;
    case (state)
      ST_HID: begin
        // bias read in phase 0, weight read in phase 1, issue in phase 2
        mreq.go = (phase == 2'd2);
        mreq.a  = feat[i_cnt[2:0]];
        mreq.b  = rdata;
      end
      ST_OUT: begin
        mreq.go = (phase == 2'd1);
        mreq.a  = rdata;
        mreq.b  = hid[j_cnt[2:0]];
      end
      ST_DHID: begin
        mreq.go = (phase == 2'd1);
        mreq.a  = rdata;
        mreq.b  = dout;
      end
      ST_OW: begin
        mreq.go = (phase == 2'd0) || (phase == 2'd2);
        mreq.a  = (phase == 2'd0) ? hid[j_cnt[2:0]] : {15'd0, learning_rate};
        mreq.b  = (phase == 2'd0) ? dout : grad;
      end
      ST_HW: begin
        mreq.go = (phase == 2'd0) || (phase == 2'd2);
        mreq.a  = (phase == 2'd0) ? feat[i_cnt[2:0]] : {15'd0, learning_rate};
        mreq.b  = (phase == 2'd0) ? dhid[j_cnt[2:0]] : grad;
      end
      ST_OB, ST_HB: begin
        // gradient is clamped in phase 0, scaled in phase 2
        mreq.go = (phase == 2'd2);
        mreq.a  = {15'd0, learning_rate};
        mreq.b  = grad;
      end
      default: mreq = '0;
    endcase
  end

  assign sum = (state == ST_OBIAS) ? {{2{acc[31]}}, acc} + {{2{rdata[31]}}, rdata}
                                   : {{2{acc[31]}}, acc} + {{2{mrsp.q[31]}}, mrsp.q};

  // Next state and memory write
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = req_idx;
    wdata = sat32({{2{rdata[31]}}, rdata} - {{2{mrsp.q[31]}}, mrsp.q});
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = '0;
        if (clr_cnt == ObIdx) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (req_t'(req_type))
            REQ_FWD:   state_next = ST_HID;
            REQ_LEARN: state_next = ST_DHID;
            REQ_WRITE: begin
              we    = weight_index <= ObIdx;
              waddr = weight_index;
              wdata = weight_value;
            end
            REQ_READ:  state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_HID:   if (phase == 2'd3 && mrsp.done && i_cnt == 4'd7) state_next = ST_RELU;
      ST_RELU:  state_next = (j_cnt == 4'd7) ? ST_OUT : ST_HID;
      ST_OUT:   if (phase == 2'd3 && mrsp.done && j_cnt == 4'd7) state_next = ST_OBIAS;
      ST_OBIAS: if (phase == 2'd1) state_next = ST_RESULT;
      ST_DHID:  if (phase == 2'd3 && mrsp.done && j_cnt == 4'd7) state_next = ST_OW;
      ST_OW: begin
        if (phase == 2'd3 && mrsp.done) begin
          we    = 1'b1;
          waddr = OwBase + {3'd0, j_cnt};
          if (j_cnt == 4'd7) state_next = ST_OB;
        end
      end
      ST_OB: begin
        if (phase == 2'd3 && mrsp.done) begin
          we = 1'b1;
          waddr = ObIdx;
          state_next = ST_HW;
        end
      end
      ST_HW: begin
        if (phase == 2'd3 && mrsp.done) begin
          we    = 1'b1;
          waddr = {1'b0, i_cnt[2:0], j_cnt[2:0]};
          if (i_cnt == 4'd7 && j_cnt == 4'd7) state_next = ST_HB;
        end
      end
      ST_HB: begin
        if (phase == 2'd3 && mrsp.done) begin
          we    = 1'b1;
          waddr = HbBase + {3'd0, j_cnt};
          if (j_cnt == 4'd7) state_next = ST_IDLE;
        end
      end
      ST_READ:   if (phase == 2'd1) state_next = ST_RESULT;
      ST_RESULT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= 2'd0;
      i_cnt     <= 4'd0;
      j_cnt     <= 4'd0;
      clr_cnt   <= 7'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Raise on a new result, drop when the beat is taken
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 7'd1;
        ST_IDLE: begin
          phase <= 2'd0;
          i_cnt <= 4'd0;
          j_cnt <= 4'd0;
        end
        ST_HID, ST_OUT, ST_DHID: begin
          // wait read, issue, wait product, accumulate (DHID stores the gradient)
          if (phase == 2'd3) begin
            if (mrsp.done) begin
              phase <= 2'd0;
              if (state == ST_HID) begin
                i_cnt <= (i_cnt == 4'd7) ? 4'd0 : i_cnt + 4'd1;
              end else begin
                j_cnt <= (j_cnt == 4'd7) ? 4'd0 : j_cnt + 4'd1;
              end
            end
          end else begin
            phase <= phase + 2'd1;
          end
        end
        ST_RELU: j_cnt <= (j_cnt == 4'd7) ? 4'd0 : j_cnt + 4'd1;
        ST_OBIAS, ST_READ: phase <= (phase == 2'd1) ? 2'd0 : phase + 2'd1;
        ST_OW, ST_OB, ST_HW, ST_HB: begin
          // grad product, clamp, lr product, write back
          if (phase == 2'd1) begin
            if (mrsp.done) phase <= 2'd2;
          end else if (phase == 2'd3) begin
            if (mrsp.done) begin
              phase <= 2'd0;
              if (state == ST_HW) begin
                j_cnt <= (j_cnt == 4'd7) ? 4'd0 : j_cnt + 4'd1;
                if (j_cnt == 4'd7) i_cnt <= (i_cnt == 4'd7) ? 4'd0 : i_cnt + 4'd1;
              end else if (state != ST_OB) begin
                j_cnt <= (j_cnt == 4'd7) ? 4'd0 : j_cnt + 4'd1;
              end
            end
          end else if (phase == 2'd0 && (state == ST_OB || state == ST_HB)) begin
            // skip the gradient product for the biases
            phase <= 2'd2;
          end else begin
            phase <= phase + 2'd1;
          end
        end
        default: phase <= 2'd0;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < InputCount; k++) feat[k] <= '0;
      for (int k = 0; k < HiddenCount; k++) hid[k] <= '0;
    end else begin
      if (state == ST_IDLE && in_valid && in_ready) begin
        req_idx    <= weight_index;
        dout       <= output_gradient;
        sat_flag   <= 1'b0;
        req_type_q <= req_t'(req_type);
        if (req_t'(req_type) == REQ_FWD) begin
          feat[0] <= feature_0;
          feat[1] <= feature_1;
          feat[2] <= feature_2;
          feat[3] <= feature_3;
          feat[4] <= feature_4;
          feat[5] <= feature_5;
          feat[6] <= feature_6;
          feat[7] <= feature_7;
        end
      end
      case (state)
        ST_HID: begin
          if (phase == 2'd1 && i_cnt == 4'd0) acc <= rdata;
          if (phase == 2'd3 && mrsp.done) begin
            acc      <= sat32(sum);
            sat_flag <= sat_flag | mrsp.sat | ovf32(sum);
          end
        end
        ST_RELU: begin
          hid[j_cnt[2:0]] <= acc[31] ? 32'sd0 : acc;
          if (j_cnt == 4'd7) acc <= '0;
        end
        ST_OUT: begin
          if (phase == 2'd3 && mrsp.done) begin
            acc      <= sat32(sum);
            sat_flag <= sat_flag | mrsp.sat | ovf32(sum);
          end
        end
        ST_OBIAS: begin
          if (phase == 2'd1) begin
            acc      <= sat32(sum);
            sat_flag <= sat_flag | ovf32(sum);
          end
        end
        ST_DHID: begin
          if (phase == 2'd3 && mrsp.done) begin
            dhid[j_cnt[2:0]] <= (hid[j_cnt[2:0]] > 32'sd0) ? mrsp.q : 32'sd0;
          end
        end
        ST_OW, ST_HW: begin
          if (phase == 2'd1 && mrsp.done) grad <= clampg(mrsp.q, gradient_clamp);
        end
        ST_OB: if (phase == 2'd0) grad <= clampg(dout, gradient_clamp);
        ST_HB: if (phase == 2'd0) grad <= clampg(dhid[j_cnt[2:0]], gradient_clamp);
        default: ;
      endcase
      if (res_load) begin
        result_kind <= (req_type_q == REQ_READ);
        prediction  <= (req_type_q == REQ_READ) ? 32'sd0 : acc;
        read_value  <= (req_type_q == REQ_READ && req_idx <= ObIdx) ? rdata : 32'sd0;
        saturated   <= (req_type_q == REQ_READ) ? 1'b0 : sat_flag;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("accept while busy");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_read_no_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind) |-> !saturated) else $error("flag on read");
`endif

endmodule

/* tb/mlp_checker.sv */
// Scoreboard for the 8-8-1 online-learning perceptron: mirrors the weight
// store and registers, predicts every result beat and compares it.
// Depends on mlp_pkg for the request codes and constants.
`timescale 1ns / 1ps
module mlp_checker import mlp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] feature_0,
  input  logic signed [31:0] feature_1,
  input  logic signed [31:0] feature_2,
  input  logic signed [31:0] feature_3,
  input  logic signed [31:0] feature_4,
  input  logic signed [31:0] feature_5,
  input  logic signed [31:0] feature_6,
  input  logic signed [31:0] feature_7,
  input  logic signed [31:0] output_gradient,
  input  logic [6:0]         weight_index,
  input  logic signed [31:0] weight_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               result_kind,
  input  logic signed [31:0] prediction,
  input  logic signed [31:0] read_value,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pred;
    logic signed [31:0] rdval;
    logic               sat;
  } result_t;

  localparam logic signed [63:0] SMax = 64'sd2147483647;
  localparam logic signed [63:0] SMin = -64'sd2147483648;

  logic signed [63:0] wstore [WeightCount];
  logic signed [63:0] feat_mem [InputCount];
  logic signed [63:0] act_mem [HiddenCount];
  logic [16:0] lr_reg;
  logic [30:0] clamp_reg;
  result_t expected_q [$];
  bit ovf;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v);
    if (v > SMax) begin
      ovf = 1;
      return SMax;
    end
    if (v < SMin) begin
      ovf = 1;
      return SMin;
    end
    return v;
  endfunction

  // Arithmetic shift floors toward minus infinity
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat64(p >>> FracBits);
  endfunction

  function automatic logic signed [63:0] lim(input logic signed [63:0] v);
    logic signed [63:0] l;
    l = {33'd0, clamp_reg};
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  task automatic run_forward(input logic signed [31:0] f [InputCount]);
    logic signed [63:0] acc;
    result_t r;
    ovf = 0;
    for (int i = 0; i < InputCount; i++) feat_mem[i] = f[i];
    for (int j = 0; j < HiddenCount; j++) begin
      acc = wstore[64 + j];
      for (int i = 0; i < InputCount; i++)
        acc = sat64(acc + qmul(feat_mem[i], wstore[i * 8 + j]));
      act_mem[j] = acc > 0 ? acc : 0;
    end
    acc = 0;
    for (int j = 0; j < HiddenCount; j++)
      acc = sat64(acc + qmul(wstore[72 + j], act_mem[j]));
    acc = sat64(acc + wstore[80]);
    r.kind = 1'b0;
    r.pred = acc[31:0];
    r.rdval = '0;
    r.sat = ovf;
    expected_q.push_back(r);
  endtask

  task automatic run_learn(input logic signed [63:0] dout);
    logic signed [63:0] lr;
    logic signed [63:0] dh [HiddenCount];
    lr = {47'd0, lr_reg};
    // hidden gradients use the output weights before the update
    for (int j = 0; j < HiddenCount; j++)
      dh[j] = act_mem[j] > 0 ? qmul(wstore[72 + j], dout) : 0;
    for (int j = 0; j < HiddenCount; j++)
      wstore[72 + j] = sat64(wstore[72 + j] - qmul(lr, lim(qmul(act_mem[j], dout))));
    wstore[80] = sat64(wstore[80] - qmul(lr, lim(dout)));
    for (int i = 0; i < InputCount; i++)
      for (int j = 0; j < HiddenCount; j++)
        wstore[i * 8 + j] = sat64(wstore[i * 8 + j] - qmul(lr, lim(qmul(feat_mem[i], dh[j]))));
    for (int j = 0; j < HiddenCount; j++)
      wstore[64 + j] = sat64(wstore[64 + j] - qmul(lr, lim(dh[j])));
  endtask

  always @(posedge clk) begin
    logic signed [31:0] f [InputCount];
    result_t r;
    result_t got;
    if (rst) begin
      for (int k = 0; k < WeightCount; k++) wstore[k] = 0;
      for (int k = 0; k < 8; k++) begin
        feat_mem[k] = 0;
        act_mem[k] = 0;
      end
      lr_reg = LrReset;
      clamp_reg = ClampReset;
      expected_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegLr) lr_reg = pwdata[16:0];
        else clamp_reg = pwdata[30:0];
      end
      // predict from the accepted input beat
      if (in_valid && in_ready) begin
        case (req_t'(req_type))
          REQ_FWD: begin
            f = '{feature_0, feature_1, feature_2, feature_3,
                  feature_4, feature_5, feature_6, feature_7};
            run_forward(f);
          end
          REQ_LEARN: run_learn(output_gradient);
          REQ_WRITE: if (weight_index < WeightCount) wstore[weight_index] = weight_value;
          REQ_READ: begin
            r.kind = 1'b1;
            r.pred = '0;
            r.rdval = weight_index < WeightCount ? wstore[weight_index][31:0] : '0;
            r.sat = 1'b0;
            expected_q.push_back(r);
          end
          default: ;
        endcase
      end
      // compare the result beat with the oldest expectation
      if (out_valid && out_ready) begin
        got = '{result_kind, prediction, read_value, saturated};
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat kind=%0d pred=%0d read=%0d sat=%0d",
                   $time, result_kind, prediction, read_value, saturated);
        end else begin
          r = expected_q.pop_front();
          if (got != r) begin
            fail_count++;
            $display("%0t: mismatch expected kind=%0d pred=%0d read=%0d sat=%0d",
                     $time, r.kind, r.pred, r.rdval, r.sat);
            $display("%0t:          actual   kind=%0d pred=%0d read=%0d sat=%0d",
                     $time, got.kind, got.pred, got.rdval, got.sat);
          end
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the 8-8-1 online-learning perceptron: APB setup,
// directed and random request beats under varied idling, checking by mlp_checker.
// Depends on mlp_pkg, mlp_8x8x1_online_learner and mlp_checker.
`timescale 1ns / 1ps
module tb_top;
  import mlp_pkg::*;

  localparam int CycleLimit = 3000000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] req_type;
  logic signed [31:0] feature_0, feature_1, feature_2, feature_3;
  logic signed [31:0] feature_4, feature_5, feature_6, feature_7;
  logic signed [31:0] output_gradient, weight_value;
  logic [6:0] weight_index;
  logic result_kind, saturated;
  logic signed [31:0] prediction, read_value;
  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int cycle_count;

  mlp_8x8x1_online_learner dut (.*);
  mlp_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(3);
      2: return 32'sh80000000 + $urandom_range(3);
      default: return $signed($urandom_range(131072)) - 65536;
    endcase
  endfunction

  // Offer one beat; valid stays up until the next beat, an idle gap or a drain drops it
  task automatic send(input req_t rq, input logic [6:0] idx, input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    req_type <= rq;
    feature_0 <= rnd_val(); feature_1 <= rnd_val(); feature_2 <= rnd_val();
    feature_3 <= rnd_val(); feature_4 <= rnd_val(); feature_5 <= rnd_val();
    feature_6 <= rnd_val(); feature_7 <= rnd_val();
    output_gradient <= rnd_val();
    weight_index <= idx;
    weight_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait for all results, then let the sequencer go idle
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (800) @(negedge clk);
  endtask

  task automatic rnd_item();
    int r;
    r = $urandom_range(99);
    if (r < 35) send(REQ_FWD, 7'd0, 32'sd0);
    else if (r < 60) send(REQ_LEARN, 7'd0, 32'sd0);
    else if (r < 80) send(REQ_WRITE, 7'($urandom_range(84)), rnd_val());
    else send(REQ_READ, 7'($urandom_range(127)), 32'sd0);
  endtask

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; req_type = 0; weight_index = 0; weight_value = 0;
    feature_0 = 0; feature_1 = 0; feature_2 = 0; feature_3 = 0;
    feature_4 = 0; feature_5 = 0; feature_6 = 0; feature_7 = 0;
    output_gradient = 0; send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 0; cycle_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: learn before any forward, index edges, field extremes
    send(REQ_LEARN, 7'd0, 32'sd0);
    send(REQ_READ, 7'd0, 32'sd0);
    send(REQ_WRITE, 7'd0, 32'sh7fffffff);
    send(REQ_WRITE, 7'd63, 32'sh80000000);
    send(REQ_WRITE, 7'd64, 32'sh00010000);
    send(REQ_WRITE, 7'd72, 32'shffff0000);
    send(REQ_WRITE, 7'd80, 32'sh00008000);
    send(REQ_WRITE, 7'd81, 32'sh12345678);
    send(REQ_WRITE, 7'd127, 32'sh12345678);
    send(REQ_READ, 7'd81, 32'sd0);
    send(REQ_READ, 7'd127, 32'sd0);
    send(REQ_READ, 7'd80, 32'sd0);
    send(REQ_FWD, 7'd0, 32'sd0);
    send(REQ_LEARN, 7'd0, 32'sd0);
    send(REQ_READ, 7'd0, 32'sd0);
    send(REQ_READ, 7'd72, 32'sd0);
    drain();

    // Largest learning rate and widest clamp, then zero rate and zero clamp
    apb_write(3'd0, 32'h0001ffff);
    apb_write(3'd4, 32'h7fffffff);
    for (int k = 0; k < 6; k++) rnd_item();
    drain();
    apb_write(3'd0, 32'd0);
    apb_write(3'd4, 32'd0);
    for (int k = 0; k < 6; k++) rnd_item();
    drain();
    apb_write(3'd0, 32'd65536);
    apb_write(3'd4, 32'd65536);

    // Random phases with varied idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 74 : 0;
      recv_stall_pct = (ph == 2) ? 74 : (ph == 3) ? 22 : 0;
      if (ph == 3) send_idle_pct = 22;
      for (int k = 0; k < 230; k++) rnd_item();
      // sender pauses until everything is back
      drain();
      apb_write(3'd0, $urandom_range(65536));
      apb_write(3'd4, $urandom_range(32'h7fffffff));
    end

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 20; k++) send(REQ_READ, 7'($urandom_range(80)), 32'sd0);
    join
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
